### hdl/dqs_pkg.sv
// Package for the bounded deque with search.
// Holds the operation and status codes and the cell control struct.
// No dependencies.
package dqs_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W = 3;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic shift_in;
    logic from_left;
  } cell_ctrl_t;

endpackage

### hdl/dqs_req_if.sv
// Request channel of the bounded deque: valid, ready, operation and value.
// Depends on dqs_pkg.
interface dqs_req_if
  import dqs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, output operation, output data_value, input ready);
  modport sink (input valid, input operation, input data_value, output ready);
endinterface

### hdl/dqs_rsp_if.sv
// Result channel of the bounded deque: valid, ready and the result fields.
// Depends on dqs_pkg; POS_W and CNT_W follow the deque depth.
interface dqs_rsp_if
  import dqs_pkg::*;
#(
  parameter int POS_W = 4,
  parameter int CNT_W = 5
) ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;
  logic [POS_W-1:0]         found_position;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, output result_value, output status,
                  output found_position, output entry_count, input ready);
  modport sink (input valid, input result_value, input status,
                input found_position, input entry_count, output ready);
endinterface

### hdl/dqs_cell.sv
// One storage cell of the deque chain: holds one value and loads from
// its left or right neighbor. Depends on dqs_pkg.
module dqs_cell
  import dqs_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (ctrl.shift_in) begin
      value <= ctrl.from_left ? left_value : right_value;
    end
  end

endmodule

### hdl/bounded_deque_with_search_core.sv
// Bounded deque of signed 32-bit values with linear search, top level.
// Depends on dqs_pkg, dqs_req_if, dqs_rsp_if and dqs_cell.
//
// Requests arrive on req (operation, data_value) and each one yields exactly
// one result on rsp (result_value, status, found_position, entry_count).
// The values sit in a chain of DEPTH cells with the front in cell 0.
// Push front and pop front shift the whole chain by one cell; the result is
// registered and shows in the cycle after the request is taken.
// Push back, pop back and search rotate the chain one full turn, one cell a
// cycle, and compare or replace the value passing cell 0; the result register
// loads at the last step of the turn. Requests that find the deque full, empty
// or carry an unused code skip the rotation and load the result directly.
// One request is in work at a time; a new request is taken as soon as the
// chain is idle and the result register is empty or being read.
// Reset empties the deque and clears the result valid flag. While the
// receiver stalls, the result is held and no new request is taken.
module bounded_deque_with_search_core
  import dqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  dqs_req_if.sink   req,
  dqs_rsp_if.source rsp
);

  localparam int POS_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [POS_W-1:0] LAST_STEP = POS_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_ROTATE = 1'b1;

  logic                     state;
  logic [POS_W-1:0]         step;
  logic [CNT_W-1:0]         count;
  logic [OP_W-1:0]          op_q;
  logic signed [DATA_W-1:0] value_q;
  logic                     hit;
  logic [POS_W-1:0]         pos;
  logic signed [DATA_W-1:0] popped;

  logic                     rsp_valid;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;
  logic [POS_W-1:0]         found_position;
  logic [CNT_W-1:0]         entry_count;

  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic signed [DATA_W-1:0] tail_in;
  cell_ctrl_t               ctrl;

  logic                     accept;
  logic                     start_rotate;
  logic                     load_result;
  logic                     in_range;
  logic                     match_now;
  logic                     hit_now;
  logic [POS_W-1:0]         pos_now;
  logic                     at_back;
  logic signed [DATA_W-1:0] popped_now;

  logic signed [DATA_W-1:0] imm_value;
  logic [STATUS_W-1:0]      imm_status;
  logic [CNT_W-1:0]         imm_count;

  logic signed [DATA_W-1:0] fin_value;
  logic [STATUS_W-1:0]      fin_status;
  logic [POS_W-1:0]         fin_pos;
  logic [CNT_W-1:0]         fin_count;

  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept = req.valid && req.ready;

  assign rsp.valid = rsp_valid;
  assign rsp.result_value = result_value;
  assign rsp.status = status;
  assign rsp.found_position = found_position;
  assign rsp.entry_count = entry_count;

  // Rotation loops cell 0 back into the tail; a push to the back replaces
  // the slot just past the last value as it goes by.
  assign tail_in = (op_q == OP_PUSH_BACK && CNT_W'(step) == count) ? value_q
                                                                    : cell_value[0];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [DATA_W-1:0] left_in;
      logic signed [DATA_W-1:0] right_in;
      if (gi == 0) begin : g_first
        assign left_in = req.data_value;
      end else begin : g_mid_l
        assign left_in = cell_value[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_in = tail_in;
      end else begin : g_mid_r
        assign right_in = cell_value[gi+1];
      end
      dqs_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .left_value  (left_in),
        .right_value (right_in),
        .value       (cell_value[gi])
      );
    end
  endgenerate

  always_comb begin
    ctrl = '0;
    start_rotate = 1'b0;
    imm_value = '0;
    imm_status = STATUS_OK;
    imm_count = count;
    if (state == S_ROTATE) begin
      ctrl.shift_in = 1'b1;
      ctrl.from_left = 1'b0;
    end else begin
      case (req.operation)
        OP_PUSH_FRONT: begin
          if (count == FULL_COUNT) begin
            imm_status = STATUS_FULL;
          end else begin
            ctrl.shift_in = accept;
            ctrl.from_left = 1'b1;
            imm_count = count + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (count == '0) begin
            imm_status = STATUS_EMPTY;
          end else begin
            ctrl.shift_in = accept;
            ctrl.from_left = 1'b0;
            imm_value = cell_value[0];
            imm_count = count - CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (count == FULL_COUNT) begin
            imm_status = STATUS_FULL;
          end else begin
            start_rotate = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (count == '0) begin
            imm_status = STATUS_EMPTY;
          end else begin
            start_rotate = 1'b1;
          end
        end
        OP_SEARCH: begin
          if (count == '0) begin
            imm_status = STATUS_NOT_FOUND;
          end else begin
            start_rotate = 1'b1;
          end
        end
        default: begin
          imm_status = STATUS_OK;
        end
      endcase
    end
  end

  assign load_result = ((state == S_IDLE) && accept && !start_rotate)
                    || ((state == S_ROTATE) && (step == LAST_STEP));

  assign in_range = CNT_W'(step) < count;
  assign match_now = (cell_value[0] == value_q) && in_range;
  assign hit_now = hit || match_now;
  assign pos_now = hit ? pos : step;
  assign at_back = CNT_W'(step) == (count - CNT_W'(1));
  assign popped_now = at_back ? cell_value[0] : popped;

  always_comb begin
    fin_value = '0;
    fin_status = STATUS_OK;
    fin_pos = '0;
    fin_count = count;
    case (op_q)
      OP_PUSH_BACK: begin
        fin_count = count + CNT_W'(1);
      end
      OP_POP_BACK: begin
        fin_value = popped_now;
        fin_count = count - CNT_W'(1);
      end
      OP_SEARCH: begin
        if (hit_now) begin
          fin_pos = pos_now;
        end else begin
          fin_status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        fin_count = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load_result) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (start_rotate) begin
              state <= S_ROTATE;
              step <= '0;
              op_q <= req.operation;
              value_q <= req.data_value;
              hit <= 1'b0;
              pos <= '0;
              popped <= '0;
            end else begin
              result_value <= imm_value;
              status <= imm_status;
              found_position <= '0;
              entry_count <= imm_count;
              count <= imm_count;
            end
          end
        end
        S_ROTATE: begin
          step <= step + POS_W'(1);
          if (op_q == OP_SEARCH && !hit && match_now) begin
            hit <= 1'b1;
            pos <= step;
          end
          if (op_q == OP_POP_BACK && at_back) begin
            popped <= cell_value[0];
          end
          if (step == LAST_STEP) begin
            state <= S_IDLE;
            result_value <= fin_value;
            status <= fin_status;
            found_position <= fin_pos;
            entry_count <= fin_count;
            count <= fin_count;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/dqs_checker.sv
// Port-level checks for the bounded deque with search, and the bind that
// attaches them to bounded_deque_with_search_core. Depends on dqs_pkg.
module dqs_checker
  import dqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic signed [DATA_W-1:0]   rsp_result_value,
  input logic [STATUS_W-1:0]        rsp_status,
  input logic [$clog2(DEPTH+1)-1:0] rsp_entry_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
      && $stable(rsp_status) && $stable(rsp_entry_count))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while result stalled");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STATUS_FULL |-> rsp_entry_count == CNT_W'(DEPTH))
    else $error("full status with room left");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STATUS_EMPTY |->
      rsp_entry_count == '0 && rsp_result_value == '0)
    else $error("empty status with values held");

endmodule

bind bounded_deque_with_search_core dqs_checker #(.DEPTH(DEPTH)) u_dqs_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_result_value (rsp.result_value),
  .rsp_status       (rsp.status),
  .rsp_entry_count  (rsp.entry_count)
);
